/* rtl/hcbd_pkg.sv */
`timescale 1ns / 1ps

package hcbd_pkg;

	localparam int SIZE_DIGITS_DEF = 8;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// what one input byte produces, if anything
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] payload;
	} result_t;

endpackage

/* rtl/hcbd_parser.sv */
`timescale 1ns / 1ps

module hcbd_parser #(
	parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              in_byte,
	output hcbd_pkg::result_t       res
);

	typedef enum logic [2:0] {
		PH_SIZE = 3'd0,
		PH_EXT  = 3'd1,
		PH_LF   = 3'd2,
		PH_DATA = 3'd3,
		PH_SKIP = 3'd4
	} phase_t;

	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;

	phase_t      phase_q, phase_d;
	logic [31:0] remaining_q, remaining_d;
	logic [3:0]  digit_count_q, digit_count_d;
	logic [1:0]  skip_count_q, skip_count_d;
	logic        final_chunk_q, final_chunk_d;

	logic [4:0]  hex_val;
	logic [31:0] rem_dec;
	logic [1:0]  skip_dec;

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39)
			v = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66)
			v = 5'(c - 8'h61 + 8'd10);
		else if (c >= 8'h41 && c <= 8'h46)
			v = 5'(c - 8'h41 + 8'd10);
		return v;
	endfunction

	assign hex_val  = hex_decode(in_byte);
	assign rem_dec  = remaining_q - 32'd1;
	assign skip_dec = skip_count_q - 2'd1;

	always_comb begin
		phase_d       = phase_q;
		remaining_d   = remaining_q;
		digit_count_d = digit_count_q;
		skip_count_d  = skip_count_q;
		final_chunk_d = final_chunk_q;
		res           = '{valid: 1'b0, kind: hcbd_pkg::KIND_PAYLOAD, payload: 8'd0};

		unique case (phase_q)
			PH_EXT: begin
				if (in_byte == CH_CR)
					phase_d = PH_LF;
			end
			PH_LF: begin
				if (in_byte != CH_LF) begin
					phase_d       = PH_SIZE;
					remaining_d   = '0;
					digit_count_d = '0;
					skip_count_d  = '0;
					final_chunk_d = 1'b0;
					res           = '{valid: 1'b1, kind: hcbd_pkg::KIND_ERROR, payload: 8'd0};
				end else begin
					digit_count_d = '0;
					if (remaining_q == '0) begin
						final_chunk_d = 1'b1;
						skip_count_d  = 2'd2;
						phase_d       = PH_SKIP;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					skip_count_d = 2'd2;
					phase_d      = PH_SKIP;
				end
				res = '{valid: 1'b1, kind: hcbd_pkg::KIND_PAYLOAD, payload: in_byte};
			end
			PH_SKIP: begin
				skip_count_d = skip_dec;
				if (skip_dec == '0) begin
					phase_d       = PH_SIZE;
					remaining_d   = '0;
					digit_count_d = '0;
					final_chunk_d = 1'b0;
					if (final_chunk_q)
						res = '{valid: 1'b1, kind: hcbd_pkg::KIND_END, payload: 8'd0};
				end
			end
			default: begin
				// size digits; unused codes land here too
				if (in_byte == CH_SEMI) begin
					phase_d = PH_EXT;
				end else if (in_byte == CH_CR) begin
					phase_d = PH_LF;
				end else if (hex_val[4] || digit_count_q >= 4'(SIZE_DIGITS) ||
				             remaining_q[31:28] != 4'd0) begin
					phase_d       = PH_SIZE;
					remaining_d   = '0;
					digit_count_d = '0;
					skip_count_d  = '0;
					final_chunk_d = 1'b0;
					res           = '{valid: 1'b1, kind: hcbd_pkg::KIND_ERROR, payload: 8'd0};
				end else begin
					remaining_d   = {remaining_q[27:0], hex_val[3:0]};
					digit_count_d = digit_count_q + 4'd1;
					phase_d       = PH_SIZE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIZE;
			remaining_q   <= '0;
			digit_count_q <= '0;
			skip_count_q  <= '0;
			final_chunk_q <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			remaining_q   <= remaining_d;
			digit_count_q <= digit_count_d;
			skip_count_q  <= skip_count_d;
			final_chunk_q <= final_chunk_d;
		end
	end

endmodule

/* rtl/http_chunked_body_deframer_core.sv */
`timescale 1ns / 1ps

// Chunked transfer deframer for an HTTP/1.1 response body.
// Input channel: in_byte with in_valid/in_ready, one raw body byte per transfer.
// Output channel: kind/payload with out_valid/out_ready. kind is payload byte,
// message end or framing error; payload is zero unless kind is payload byte.
// Size line, extension, CRLF and trailing pair bytes give no payload output.
// Path: a byte is registered at the input, decoded against the parser state,
// and its result lands in the output register that drives out_valid.
// Throughput: one byte per cycle while the output does not stall; the parser
// state steps on every byte, so back-to-back bytes are taken without gaps.
// Stall: when out_ready is low and a result is held, the input register
// keeps its byte if it would produce a result, and in_ready drops once that
// register is occupied. Bytes that produce no result still advance.
// Reset (arst_n low): both registers empty, parser expects size digits.
// After message end or an error the parser restarts on a new size line.
// SIZE_DIGITS caps the hex digits of one size, leading zeros included.

module http_chunked_body_deframer_core #(
	parameter int SIZE_DIGITS = hcbd_pkg::SIZE_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] payload
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        payload_q;
	logic              advance;
	hcbd_pkg::result_t res;

	hcbd_parser #(
		.SIZE_DIGITS(SIZE_DIGITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.in_byte(byte_s1),
		.res    (res)
	);

	// a byte leaves s1 unless it has a result and the output slot stays full
	assign advance  = valid_s1 && (!res.valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q    <= res.kind;
			payload_q <= res.payload;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign payload   = payload_q;

endmodule

/* tb/hcbd_tb_pkg.sv */
`timescale 1ns / 1ps

package hcbd_tb_pkg;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_EXT,
		PH_LF,
		PH_DATA,
		PH_SKIP
	} parse_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} deframed_t;

	// 0..15 for a hex digit, 16 for anything else
	function automatic logic [4:0] hex_value(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 5'(c - "0");
		if (c >= "a" && c <= "f")
			return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F")
			return 5'(c - "A" + 10);
		return 5'd16;
	endfunction

	class deframe_checker;
		parse_phase_t phase;
		logic [31:0]  remaining;
		logic [3:0]   digit_count;
		logic [1:0]   skip_count;
		bit           final_chunk;
		deframed_t    pending_beats[$];
		int           mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			phase       = PH_SIZE;
			remaining   = '0;
			digit_count = '0;
			skip_count  = '0;
			final_chunk = 1'b0;
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction

		function void expect_beat(logic [1:0] k, logic [7:0] d);
			deframed_t beat;
			beat.kind = k;
			beat.data = d;
			pending_beats.push_back(beat);
		endfunction

		// advance the parser by one accepted body byte
		function void note_byte(logic [7:0] b);
			logic [4:0] d;
			case (phase)
				PH_EXT: begin
					if (b == CH_CR)
						phase = PH_LF;
				end
				PH_LF: begin
					if (b != CH_LF) begin
						restart();
						expect_beat(hcbd_pkg::KIND_ERROR, 8'h00);
					end else begin
						digit_count = '0;
						if (remaining == 0) begin
							final_chunk = 1'b1;
							skip_count  = 2'd2;
							phase       = PH_SKIP;
						end else begin
							phase = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					remaining = remaining - 1;
					if (remaining == 0) begin
						skip_count = 2'd2;
						phase      = PH_SKIP;
					end
					expect_beat(hcbd_pkg::KIND_PAYLOAD, b);
				end
				PH_SKIP: begin
					skip_count = skip_count - 1'b1;
					if (skip_count == 0) begin
						if (final_chunk)
							expect_beat(hcbd_pkg::KIND_END, 8'h00);
						restart();
					end
				end
				default: begin
					if (b == CH_SEMI) begin
						phase = PH_EXT;
					end else if (b == CH_CR) begin
						phase = PH_LF;
					end else begin
						d = hex_value(b);
						// digit limit counts leading zeros; never truncate
						if (d[4] || digit_count >= hcbd_pkg::SIZE_DIGITS_DEF ||
						    remaining[31:28] != 0) begin
							restart();
							expect_beat(hcbd_pkg::KIND_ERROR, 8'h00);
						end else begin
							remaining   = {remaining[27:0], d[3:0]};
							digit_count = digit_count + 1'b1;
							phase       = PH_SIZE;
						end
					end
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [1:0] k, logic [7:0] p);
			deframed_t exp;
			if (pending_beats.size() == 0) begin
				report($sformatf("kind %0d payload %02h with nothing expected", k, p));
				return;
			end
			exp = pending_beats.pop_front();
			if (k !== exp.kind)
				report($sformatf("kind %0d, expected %0d", k, exp.kind));
			if (p !== exp.data)
				report($sformatf("payload %02h, expected %02h", p, exp.data));
		endtask
	endclass

endpackage

/* tb/tb_http_chunked_body_deframer_core.sv */
`timescale 1ns / 1ps

module tb_http_chunked_body_deframer_core;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BYTES = 380;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       out_ready = 1'b0;
	wire        in_ready;
	wire        out_valid;
	wire  [1:0] kind;
	wire  [7:0] payload;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int bytes_sent = 0;
	int quiet_cycles = 0;

	hcbd_tb_pkg::deframe_checker sb = new();

	logic [7:0] directed_seq[$] = '{
		// empty size line: last chunk, trailer bytes at both extremes
		hcbd_tb_pkg::CH_CR, hcbd_tb_pkg::CH_LF, 8'hFF, 8'h00,
		// size 1 with an extension, payload ff
		"1", hcbd_tb_pkg::CH_SEMI, 8'h00, 8'hFF, hcbd_tb_pkg::CH_CR, hcbd_tb_pkg::CH_LF,
		8'hFF, 8'h00, 8'h00,
		// explicit zero size
		"0", hcbd_tb_pkg::CH_CR, hcbd_tb_pkg::CH_LF, 8'h55, 8'hAA,
		// bad size character
		"G",
		// CR not followed by LF
		hcbd_tb_pkg::CH_CR, "x",
		// one digit past the limit, leading zeros included
		"0", "0", "0", "0", "0", "0", "0", "0", "1"
	};

	http_chunked_body_deframer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.payload   (payload)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(kind, payload);
			if (in_valid && in_ready)
				sb.note_byte(in_byte);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
		if (v < 10)
			return 8'("0" + v);
		return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_digit();
		send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
	endtask

	task automatic send_size(input logic [31:0] size, input bit allow_empty);
		int nd;
		int pad;
		nd = 0;
		for (int i = 0; i < 8; i++)
			if ((size >> (4 * i)) != 0)
				nd = i + 1;
		if (nd == 0 && !(allow_empty && $urandom_range(1)))
			nd = 1;
		pad = 0;
		if (nd > 0 && $urandom_range(3) == 0)
			pad = $urandom_range(hcbd_pkg::SIZE_DIGITS_DEF - nd);
		repeat (pad) send_byte("0");
		for (int i = nd - 1; i >= 0; i--)
			send_byte(hex_char(size[4 * i +: 4], 1'($urandom_range(1))));
	endtask

	// optional extension, CR, then LF or (when broken) some other byte
	task automatic send_line_end(input bit good);
		logic [7:0] b;
		int n;
		if ($urandom_range(3) == 0) begin
			send_byte(hcbd_tb_pkg::CH_SEMI);
			n = $urandom_range(5);
			repeat (n) begin
				b = 8'($urandom_range(255));
				if (b == hcbd_tb_pkg::CH_CR)
					b = ~b;
				send_byte(b);
			end
		end
		send_byte(hcbd_tb_pkg::CH_CR);
		if (good) begin
			send_byte(hcbd_tb_pkg::CH_LF);
		end else begin
			do
				b = 8'($urandom_range(255));
			while (b == hcbd_tb_pkg::CH_LF);
			send_byte(b);
		end
	endtask

	task automatic send_chunk(input int unsigned size);
		send_size(size, size == 0);
		send_line_end(1'b1);
		repeat (size) send_byte(8'($urandom_range(255)));
		repeat (2) send_byte(8'($urandom_range(255)));
	endtask

	function automatic int unsigned pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 64);
		return $urandom_range(65, 300);
	endfunction

	task automatic send_message();
		int n;
		n = $urandom_range(3);
		repeat (n) send_chunk(pick_size());
		send_chunk(0);
	endtask

	// every broken sequence starts and ends with the parser on a fresh size line
	task automatic send_broken();
		logic [7:0] b;
		logic [4:0] hv;
		int n;
		case ($urandom_range(3))
			0: begin
				n = $urandom_range(3);
				repeat (n) send_digit();
				do begin
					b  = 8'($urandom_range(255));
					hv = hcbd_tb_pkg::hex_value(b);
				end while (!hv[4] || b == hcbd_tb_pkg::CH_SEMI || b == hcbd_tb_pkg::CH_CR);
				send_byte(b);
			end
			1: begin
				repeat (hcbd_pkg::SIZE_DIGITS_DEF + 1) send_digit();
			end
			2: begin
				n = $urandom_range(3);
				repeat (n) send_digit();
				send_line_end(1'b0);
			end
			default: begin
				// without LF the parser never leaves the size line; CR plus 'x' resyncs
				n = $urandom_range(1, 8);
				repeat (n) begin
					do
						b = 8'($urandom_range(255));
					while (b == hcbd_tb_pkg::CH_LF);
					send_byte(b);
				end
				send_byte(hcbd_tb_pkg::CH_CR);
				send_byte("x");
			end
		endcase
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_seq[i])
			send_byte(directed_seq[i]);
		wait_results_drained();

		// receiver holds off while a long chunk is offered, so the input stalls
		hold_cycles = HOLD_CYCLES;
		send_chunk(64);
		send_chunk(0);
		wait_results_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 46;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 46;
				end
				default: begin
					send_idle_pct  = 8;
					recv_stall_pct = 8;
				end
			endcase
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				if ($urandom_range(99) < 80)
					send_message();
				else
					send_broken();
			end
			wait_results_drained();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
